### rtl/i2ces_pkg.sv
// ----------------------------------------------------------------------------
// i2ces_pkg
// shared types and constants for the i2c eeprom slave unit
// ----------------------------------------------------------------------------
package i2ces_pkg;

  localparam int MEM_BYTES = 8192;
  localparam int MEM_AW    = $clog2(MEM_BYTES);

  localparam logic [6:0] DEV_ADDR_RESET = 7'h50;
  localparam logic [7:0] PORT_IDLE      = 8'hFF;
  localparam logic [7:0] MEM_BLANK      = 8'hFF;
  localparam int         SDA_BIT        = 2;
  localparam logic [3:0] BYTE_BITS      = 4'd8;
  localparam logic [1:0] LINES_IDLE     = 2'b11;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_DEV  = 3'd1,
    PH_AHI  = 3'd2,
    PH_DATA = 3'd3,
    PH_ALO  = 3'd4
  } phase_t;

  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [MEM_AW-1:0] raddr;
  } mem_req_t;

  function automatic logic addr_in_range(input logic [15:0] a);
    addr_in_range = ({1'b0, a} < 17'(MEM_BYTES));
  endfunction

endpackage

### rtl/i2c_eeprom_slave_unit.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_slave_unit
// bit-banged i2c eeprom slave with two-byte word address and byte store
// ----------------------------------------------------------------------------
// one item accepted per cycle while in_stall is low; line updates act on the state at the accepting edge
// a port read registers its result into the output queue; port_value shows it once earlier results are taken
// store reads are synchronous (registered read); the fetched byte is used from the
//   read register directly, so it never holds up the next item
// rst (synchronous) clears control state and starts a fill sweep writing 0xff to
//   all MEM_BYTES (8192) locations; in_stall stays high for that sweep
module i2c_eeprom_slave_unit (
  input  logic       clk,
  input  logic       rst,
  // configuration: device address
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       op,
  input  logic       scl_level,
  input  logic       sda_level,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] port_value
);

  i2ces_pkg::mem_req_t mem_req;
  logic [7:0]          mem_rdata;
  logic                store_busy;
  logic                q_full;
  logic                fire;
  logic                push;
  logic [7:0]          result;

  // stall during the fill sweep or while both queue entries hold results
  assign in_stall = store_busy || q_full;
  assign fire     = in_valid && !in_stall;

  // protocol engine: edges, shifting, ack, word address
  i2ces_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .op        (op),
    .scl       (scl_level),
    .sda       (sda_level),
    .mem_rdata (mem_rdata),
    .mem_req   (mem_req),
    .push      (push),
    .result    (result)
  );

  // eeprom array
  i2ces_store u_store (
    .clk   (clk),
    .rst   (rst),
    .req   (mem_req),
    .rdata (mem_rdata),
    .busy  (store_busy)
  );

  // result register plus skid so a single waiting result does not block line updates
  i2ces_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .din        (result),
    .full       (q_full),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .port_value (port_value)
  );

`ifndef SYNTHESIS
  a_read_gives_result: assert property (@(posedge clk) disable iff (rst)
    (fire && op) |=> out_valid)
    else $error("port read transfer produced no result");
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    store_busy |-> !fire && !push)
    else $error("item accepted during fill sweep");
`endif

endmodule

### rtl/i2ces_store.sv
// ----------------------------------------------------------------------------
// i2ces_store
// byte store with registered read and a fill sweep to 0xff after reset
// ----------------------------------------------------------------------------
module i2ces_store (
  input  logic                      clk,
  input  logic                      rst,
  input  i2ces_pkg::mem_req_t       req,
  output logic [7:0]                rdata,
  output logic                      busy
);

  logic [7:0]                   mem [i2ces_pkg::MEM_BYTES];
  logic [i2ces_pkg::MEM_AW-1:0] clr_addr;
  logic                         clearing;
  logic                         wr_en;
  logic [i2ces_pkg::MEM_AW-1:0] wr_addr;
  logic [7:0]                   wr_data;

  assign busy = clearing;

  // sweep owns the write port until done
  always_comb begin
    if (clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = i2ces_pkg::MEM_BLANK;
    end else begin
      wr_en   = req.we;
      wr_addr = req.waddr;
      wr_data = req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == i2ces_pkg::MEM_AW'(i2ces_pkg::MEM_BYTES - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

`ifndef SYNTHESIS
  a_no_write_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !req.we && !req.re)
    else $error("store access during fill sweep");
`endif

endmodule

### rtl/i2ces_outq.sv
// ----------------------------------------------------------------------------
// i2ces_outq
// two-entry result queue: output register plus skid entry
// ----------------------------------------------------------------------------
module i2ces_outq (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] din,
  output logic       full,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] port_value
);

  logic [1:0] cnt;
  logic [1:0] cnt_next;
  logic [7:0] head;
  logic [7:0] skid;
  logic       pop;

  assign pop        = out_valid && !out_stall;
  assign out_valid  = (cnt != 2'd0);
  assign full       = (cnt == 2'd2);
  assign port_value = head;

  always_comb begin
    cnt_next = cnt;
    if (push && !pop) begin
      cnt_next = cnt + 2'd1;
    end else if (pop && !push) begin
      cnt_next = cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && cnt == 2'd1) begin
        head <= din;
      end else begin
        head <= skid;
      end
      if (push && cnt == 2'd2) begin
        skid <= din;
      end
    end else if (push) begin
      if (cnt == 2'd0) begin
        head <= din;
      end else begin
        skid <= din;
      end
    end
  end

`ifndef SYNTHESIS
  a_last_pop_empties: assert property (@(posedge clk) disable iff (rst)
    (pop && !push && cnt == 2'd1) |=> !out_valid)
    else $error("queue not empty after last transfer");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (push && full) |-> pop)
    else $error("push into full queue");
`endif

endmodule

### rtl/i2ces_engine.sv
// ----------------------------------------------------------------------------
// i2ces_engine
// line edge decode, byte shifter, ack timing and word address control
// ----------------------------------------------------------------------------
module i2ces_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_wdata,
  input  logic                fire,
  input  logic                op,
  input  logic                scl,
  input  logic                sda,
  input  logic [7:0]          mem_rdata,
  output i2ces_pkg::mem_req_t mem_req,
  output logic                push,
  output logic [7:0]          result
);

  logic [6:0]        dev_addr;
  logic [1:0]        cur_lines,     cur_lines_next;
  i2ces_pkg::phase_t phase,         phase_next;
  logic [3:0]        bit_count,     bit_count_next;
  logic [7:0]        shift_in,      shift_in_next;
  logic              read_mode,     read_mode_next;
  logic              matched,       matched_next;
  logic [15:0]       word_address,  word_address_next;
  logic [7:0]        shift_out,     shift_out_next;
  logic [3:0]        out_bit_count, out_bit_count_next;
  logic              ack_pending,   ack_pending_next;
  logic              ack_drive,     ack_drive_next;
  logic              so_mem,        so_mem_next;
  logic              so_oor,        so_oor_next;

  logic [7:0]  so_eff;
  logic        active;
  logic        scl_p;
  logic        sda_p;
  logic        load;
  logic [15:0] load_addr;
  logic [15:0] wa_inc;

  // after a load, so_eff takes the byte from the store's read register in place of shift_out
  assign so_eff = so_mem ? (so_oor ? i2ces_pkg::MEM_BLANK : mem_rdata) : shift_out;
  assign active = (phase == i2ces_pkg::PH_DEV) || (phase == i2ces_pkg::PH_AHI) ||
                  (phase == i2ces_pkg::PH_DATA) || (phase == i2ces_pkg::PH_ALO);
  assign scl_p  = cur_lines[1];
  assign sda_p  = cur_lines[0];
  assign wa_inc = word_address + 16'd1;
  assign push   = fire && op;

  always_comb begin
    result = i2ces_pkg::PORT_IDLE;
    if (active && (ack_drive || (read_mode && matched && phase == i2ces_pkg::PH_DATA &&
        out_bit_count < i2ces_pkg::BYTE_BITS && !so_eff[7]))) begin
      result[i2ces_pkg::SDA_BIT] = 1'b0;
    end
  end

  always_comb begin
    cur_lines_next     = cur_lines;
    phase_next         = phase;
    bit_count_next     = bit_count;
    shift_in_next      = shift_in;
    read_mode_next     = read_mode;
    matched_next       = matched;
    word_address_next  = word_address;
    shift_out_next     = shift_out;
    out_bit_count_next = out_bit_count;
    ack_pending_next   = ack_pending;
    ack_drive_next     = ack_drive;
    so_mem_next        = so_mem;
    so_oor_next        = so_oor;
    mem_req            = '0;
    load               = 1'b0;
    load_addr          = word_address;

    if (fire && !op) begin
      cur_lines_next = {scl, sda};
      if (scl && scl_p && !sda && sda_p) begin
        // start
        phase_next         = i2ces_pkg::PH_DEV;
        bit_count_next     = '0;
        shift_in_next      = '0;
        ack_pending_next   = 1'b0;
        ack_drive_next     = 1'b0;
        word_address_next  = '0;
        read_mode_next     = 1'b0;
        matched_next       = 1'b0;
        out_bit_count_next = '0;
      end else if (scl && scl_p && sda && !sda_p) begin
        // stop
        phase_next       = i2ces_pkg::PH_IDLE;
        ack_pending_next = 1'b0;
        ack_drive_next   = 1'b0;
        read_mode_next   = 1'b0;
        matched_next     = 1'b0;
      end else if (scl && !scl_p) begin
        if (active && !(phase == i2ces_pkg::PH_DATA && read_mode)) begin
          if (ack_pending) begin
            ack_pending_next = 1'b0;
            bit_count_next   = '0;
            shift_in_next    = '0;
            case (phase)
              i2ces_pkg::PH_DEV: begin
                if (shift_in[7:1] == dev_addr) begin
                  matched_next       = 1'b1;
                  read_mode_next     = shift_in[0];
                  phase_next         = shift_in[0] ? i2ces_pkg::PH_DATA : i2ces_pkg::PH_AHI;
                  out_bit_count_next = '0;
                end else begin
                  phase_next     = i2ces_pkg::PH_IDLE;
                  matched_next   = 1'b0;
                  ack_drive_next = 1'b0;
                end
              end
              i2ces_pkg::PH_AHI: begin
                word_address_next = {shift_in, 8'h00};
                phase_next        = i2ces_pkg::PH_ALO;
              end
              i2ces_pkg::PH_ALO: begin
                word_address_next = {word_address[15:8], word_address[7:0] | shift_in};
                phase_next        = i2ces_pkg::PH_DATA;
              end
              default: begin
                // write data byte
                if (i2ces_pkg::addr_in_range(word_address)) begin
                  mem_req.we    = 1'b1;
                  mem_req.waddr = word_address[i2ces_pkg::MEM_AW-1:0];
                  mem_req.wdata = shift_in;
                end
                word_address_next = wa_inc;
              end
            endcase
          end else if (bit_count < i2ces_pkg::BYTE_BITS) begin
            shift_in_next  = {shift_in[6:0], sda};
            bit_count_next = bit_count + 4'd1;
            if (bit_count + 4'd1 == i2ces_pkg::BYTE_BITS) begin
              ack_pending_next = 1'b1;
            end
          end
        end
      end else if (!scl && scl_p) begin
        if (active) begin
          if (ack_drive) begin
            ack_drive_next = 1'b0;
            if (read_mode && phase == i2ces_pkg::PH_DATA) begin
              load = 1'b1;
            end
          end else if (ack_pending) begin
            if (phase == i2ces_pkg::PH_DEV) begin
              ack_drive_next = (shift_in[7:1] == dev_addr);
            end else begin
              ack_drive_next = 1'b1;
            end
          end else if (read_mode && phase == i2ces_pkg::PH_DATA) begin
            if (out_bit_count < i2ces_pkg::BYTE_BITS) begin
              shift_out_next     = {so_eff[6:0], 1'b0};
              so_mem_next        = 1'b0;
              out_bit_count_next = out_bit_count + 4'd1;
            end else begin
              word_address_next = wa_inc;
              load_addr         = wa_inc;
              load              = 1'b1;
            end
          end
        end
      end
    end

    if (load) begin
      mem_req.re         = 1'b1;
      mem_req.raddr      = load_addr[i2ces_pkg::MEM_AW-1:0];
      so_mem_next        = 1'b1;
      so_oor_next        = !i2ces_pkg::addr_in_range(load_addr);
      out_bit_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_addr <= i2ces_pkg::DEV_ADDR_RESET;
    end else if (cfg_we) begin
      dev_addr <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_lines     <= i2ces_pkg::LINES_IDLE;
      phase         <= i2ces_pkg::PH_IDLE;
      bit_count     <= '0;
      shift_in      <= '0;
      read_mode     <= 1'b0;
      matched       <= 1'b0;
      word_address  <= '0;
      shift_out     <= '0;
      out_bit_count <= '0;
      ack_pending   <= 1'b0;
      ack_drive     <= 1'b0;
      so_mem        <= 1'b0;
      so_oor        <= 1'b0;
    end else begin
      cur_lines     <= cur_lines_next;
      phase         <= phase_next;
      bit_count     <= bit_count_next;
      shift_in      <= shift_in_next;
      read_mode     <= read_mode_next;
      matched       <= matched_next;
      word_address  <= word_address_next;
      shift_out     <= shift_out_next;
      out_bit_count <= out_bit_count_next;
      ack_pending   <= ack_pending_next;
      ack_drive     <= ack_drive_next;
      so_mem        <= so_mem_next;
      so_oor        <= so_oor_next;
    end
  end

`ifndef SYNTHESIS
  a_ack_after_full_byte: assert property (@(posedge clk) disable iff (rst)
    ack_pending |-> bit_count == i2ces_pkg::BYTE_BITS)
    else $error("ack pending without a full byte");
  a_load_in_read_data: assert property (@(posedge clk) disable iff (rst)
    mem_req.re |-> (read_mode && phase == i2ces_pkg::PH_DATA && !mem_req.we))
    else $error("store read outside read data phase");
`endif

endmodule
